// ----- hdl/assert_macros.svh -----
// shared assertion macros for the heap queue checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bmhq_pkg.sv -----
`default_nettype none

package bmhq_pkg;

  // widths fixed by the item fields
  localparam int KEY_W   = 16;
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 7;

  // default heap depth
  localparam int HQ_CAPACITY = 64;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] entry_key;
    logic [TAG_W-1:0] entry_tag;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   top_key;
    logic [TAG_W-1:0]   top_tag;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               overflow;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/binary_max_heap_queue.sv -----
// channel | direction | handshake              | payload
// cmd     | in        | cmd_valid / cmd_ready  | cmd (action, entry_key, entry_tag)
// rsp     | out       | rsp_valid / rsp_ready  | rsp (top_key, top_tag, entry_count,
//         |           |                        |      is_empty, overflow)
//
// one item at a time; cmd_ready is high only while the sequencer is idle
// per item, accept through result load: each level moved is one registered memory
// read (ST_UP or ST_DN) then one pass through the compare unit (ST_UP_CMP or
// ST_DN_CMP); a remove first loads the last entry as the moving one (ST_DN_LOAD);
// a dropped insert or an empty remove goes straight to the result step (ST_DONE)
// rst is synchronous; it empties the heap, the store itself is not cleared
// a result waiting on rsp_ready holds the sequencer in its final step
`default_nettype none

module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = HQ_CAPACITY
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output rsp_t rsp
);

  // index and count widths
  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = AW + 2;

  // entry store: one write port, two registered read ports
  entry_t mem [CAPACITY];
  entry_t rd_a;
  entry_t rd_b;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;

  // sequencer registers
  state_t         state;
  state_t         state_next;
  logic [CNT_W-1:0] count;
  logic [AW-1:0]  pos;
  entry_t         mov;      // entry being sifted, kept out of the store
  entry_t         top;      // shadow copy of the root slot
  logic           ovf;

  // index arithmetic
  logic [CNT_W-1:0] count_dec;
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    parent_idx;
  logic [IW-1:0]    pos_w;
  logic [IW-1:0]    left_w;
  logic [IW-1:0]    right_w;
  logic [IW-1:0]    count_w;
  logic             full;
  logic             empty;
  logic             has_left;
  logic             right_ok;

  // compare unit results
  logic             climb;      // moving entry beats its parent
  logic             pick_right;
  entry_t           pick_e;
  logic [AW-1:0]    pick_idx;
  logic             sink;       // chosen child beats the moving entry

  logic             accept;
  logic             rsp_free;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign accept   = cmd_valid && cmd_ready;
  assign rsp_free = !rsp_valid || rsp_ready;

  assign count_dec  = count - CNT_W'(1);
  assign last_idx   = count_dec[AW-1:0];
  assign parent_idx = (pos - AW'(1)) >> 1;
  assign pos_w      = IW'(pos);
  assign left_w     = (pos_w << 1) + IW'(1);
  assign right_w    = left_w + IW'(1);
  assign count_w    = IW'(count);
  assign full       = (count == CNT_W'(CAPACITY));
  assign empty      = (count == '0);
  assign has_left   = (left_w < count_w);
  assign right_ok   = (right_w < count_w);

  assign climb      = (mov.key > rd_a.key);
  assign pick_right = right_ok && (rd_b.key > rd_a.key);
  assign pick_e     = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign sink       = (pick_e.key > mov.key);

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.action == ACT_INSERT) begin
            state_next = full ? ST_DONE : ST_UP;
          end else begin
            state_next = empty ? ST_DONE : ST_DN_LOAD;
          end
        end
      end
      ST_UP:      state_next = (pos == '0) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:  state_next = climb ? ST_UP : ST_DONE;
      ST_DN_LOAD: state_next = ST_DN;
      ST_DN:      state_next = has_left ? ST_DN_CMP : ST_DONE;
      ST_DN_CMP:  state_next = sink ? ST_DN : ST_DONE;
      ST_DONE:    state_next = rsp_free ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    cmd_ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = mov;
    raddr_a   = parent_idx;
    raddr_b   = right_w[AW-1:0];
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        raddr_a   = last_idx;        // last entry, used by a remove
      end
      ST_UP: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (climb) begin
          mem_wdata = rd_a;          // parent moves down into the hole
        end
      end
      ST_DN: begin
        raddr_a = left_w[AW-1:0];
        if (!has_left) begin
          mem_we = 1'b1;
        end
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (sink) begin
          mem_wdata = pick_e;        // child moves up into the hole
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new result loads as the old one leaves, otherwise the taken one clears
      if ((state == ST_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd.action == ACT_INSERT) begin
              if (!full) begin
                count <= count + CNT_W'(1);
              end
            end else if (!empty) begin
              count <= count_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (mem_we && (mem_waddr == '0)) begin
      top <= mem_wdata;
    end
    case (state)
      ST_IDLE: begin
        ovf <= full && (cmd.action == ACT_INSERT);
        mov <= '{key: cmd.entry_key, tag: cmd.entry_tag};
        pos <= count[AW-1:0];        // first free slot
      end
      ST_UP_CMP: begin
        if (climb) begin
          pos <= parent_idx;
        end
      end
      ST_DN_LOAD: begin
        mov <= rd_a;
        pos <= '0;
      end
      ST_DN_CMP: begin
        if (sink) begin
          pos <= pick_idx;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp.top_key     <= empty ? '0 : top.key;
          rsp.top_tag     <= empty ? '0 : top.tag;
          rsp.entry_count <= count_ext[COUNT_W-1:0];
          rsp.is_empty    <= empty;
          rsp.overflow    <= ovf;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/bmhq_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module bmhq_checker
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = HQ_CAPACITY
) (
  input wire  clk,
  input wire  rst,
  input wire  cmd_valid,
  input wire  cmd_ready,
  input cmd_t cmd,
  input wire  rsp_valid,
  input wire  rsp_ready,
  input rsp_t rsp
);

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  // a waiting result holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // empty flag agrees with the count
  `ASSERT_IMPLY(a_empty_count, clk, rst, rsp_valid, rsp.is_empty == (rsp.entry_count == '0), "is_empty disagrees with entry_count")

  // a dropped insert only happens on a full heap
  `ASSERT_IMPLY(a_ovf_full, clk, rst, rsp_valid && rsp.overflow, rsp.entry_count == CAP_CNT && !rsp.is_empty, "overflow without a full heap")

  // one item in flight: no new item right after an accept
  `ASSERT_NEXT(a_busy, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "cmd_ready high while busy")

  // count never exceeds the depth
  `ASSERT_IMPLY(a_count_range, clk, rst, rsp_valid, rsp.entry_count <= CAP_CNT, "entry_count beyond capacity")

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// ----- test/binary_max_heap_queue_test.sv -----
`timescale 1ns / 100ps

module binary_max_heap_queue_test;
  import bmhq_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CALM_TAIL    = 150;   // items at the end sent with no idling
  localparam int LONG_HOLD    = 400;   // cycles the receiver holds off once
  localparam int HOLD_AT      = 500;   // result count that starts the hold-off
  localparam int PAUSE_AT     = 700;   // random item after which the sender drains
  localparam int SETTLE       = 24;    // wait after the last result before the summary
  localparam int PRINT_CAP    = 40;

  // root view of an empty heap
  localparam rsp_t EMPTY_TOP = {16'h0000, 16'h0000, 7'd0, 1'b1, 1'b0};
  localparam rsp_t NO_WANT   = '0;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_TIES} seg_kind_t;

  // one directed item; want is used only when typed is set
  typedef struct packed {
    cmd_t cmd;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  binary_max_heap_queue #(
    .CAPACITY(HQ_CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // heap predictor state, a plain array heap with the root at slot 0
  logic [KEY_W-1:0] heap_keys [HQ_CAPACITY];
  logic [TAG_W-1:0] heap_tags [HQ_CAPACITY];
  int               heap_fill = 0;

  // root views still owed by the block, oldest first
  rsp_t pending_tops [$];

  dir_row_t dir_table [24];

  int  mismatches     = 0;
  int  results_seen   = 0;
  int  n_insert       = 0;
  int  n_remove       = 0;
  int  n_dropped      = 0;
  int  n_empty_remove = 0;
  int  peak_fill      = 0;
  bit  calm           = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous fixed limit, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results still owed", pending_tops.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch on result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  function automatic void heap_swap(input int a, input int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = heap_keys[a];
    t = heap_tags[a];
    heap_keys[a] = heap_keys[b];
    heap_tags[a] = heap_tags[b];
    heap_keys[b] = k;
    heap_tags[b] = t;
  endfunction

  // applies one item to the predictor heap and returns the root view after it
  function automatic rsp_t heap_apply(input cmd_t c);
    int   pos;
    int   up;
    int   left;
    int   right;
    int   pick;
    bit   moving;
    rsp_t r;
    r = '0;
    if (c.action == ACT_INSERT) begin
      if (heap_fill >= HQ_CAPACITY) begin
        r.overflow = 1'b1;
      end else begin
        pos = heap_fill;
        heap_keys[pos] = c.entry_key;
        heap_tags[pos] = c.entry_tag;
        // climb only while strictly greater than the parent
        while (pos > 0 && heap_keys[pos] > heap_keys[(pos - 1) / 2]) begin
          up = (pos - 1) / 2;
          heap_swap(pos, up);
          pos = up;
        end
        heap_fill++;
      end
    end else if (heap_fill > 0) begin
      heap_fill--;
      heap_keys[0] = heap_keys[heap_fill];
      heap_tags[0] = heap_tags[heap_fill];
      pos = 0;
      moving = 1'b1;
      while (moving) begin
        left = 2 * pos + 1;
        right = left + 1;
        if (left >= heap_fill) begin
          moving = 1'b0;
        end else begin
          // larger child wins, a tie goes left, a missing right child is skipped
          pick = left;
          if (right < heap_fill && heap_keys[right] > heap_keys[left])
            pick = right;
          if (heap_keys[pick] > heap_keys[pos]) begin
            heap_swap(pos, pick);
            pos = pick;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end
    r.entry_count = COUNT_W'(heap_fill);
    r.is_empty = (heap_fill == 0);
    if (heap_fill > 0) begin
      r.top_key = heap_keys[0];
      r.top_tag = heap_tags[0];
    end
    return r;
  endfunction

  // spread 0: any key, 1: a few small keys, 2: edge values
  function automatic logic [KEY_W-1:0] pick_key(input int spread);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom());
    if (spread == 1) begin
      k = KEY_W'($urandom_range(0, 7));
    end else if (spread == 2) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = {1'b1, {(KEY_W - 1){1'b0}}};
        default: k = {1'b0, {(KEY_W - 1){1'b1}}};
      endcase
    end
    return k;
  endfunction

  // offers one item, holds it until accepted, then books its root view
  task automatic offer_cmd(input cmd_t c, input bit typed, input rsp_t want);
    bit   was_empty;
    rsp_t r;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    was_empty = (heap_fill == 0);
    r = heap_apply(c);
    if (c.action == ACT_INSERT) begin
      n_insert++;
      if (r.overflow) n_dropped++;
    end else begin
      n_remove++;
      if (was_empty) n_empty_remove++;
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    pending_tops.push_back(typed ? want : r);
  endtask

  // random gap between items, none once the run has gone calm
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off, checks every result in order
  initial begin
    int   stall_left;
    bit   long_done;
    rsp_t want;
    stall_left = 0;
    long_done = 1'b0;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (pending_tops.size() == 0) begin
          note_mismatch("result with no item outstanding");
        end else begin
          want = pending_tops.pop_front();
          if (rsp.top_key !== want.top_key)
            note_mismatch($sformatf("top_key %h, want %h", rsp.top_key, want.top_key));
          if (rsp.top_tag !== want.top_tag)
            note_mismatch($sformatf("top_tag %h, want %h", rsp.top_tag, want.top_tag));
          if (rsp.entry_count !== want.entry_count)
            note_mismatch($sformatf("entry_count %0d, want %0d",
                                    rsp.entry_count, want.entry_count));
          if (rsp.is_empty !== want.is_empty)
            note_mismatch($sformatf("is_empty %b, want %b", rsp.is_empty, want.is_empty));
          if (rsp.overflow !== want.overflow)
            note_mismatch($sformatf("overflow %b, want %b", rsp.overflow, want.overflow));
        end
      end
      // the long hold-off lets the block sit on a finished item while the
      // sender keeps its next item waiting
      if (!long_done && results_seen >= HOLD_AT) begin
        long_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // sender and run control
  initial begin
    int        i;
    int        j;
    int        seg_len;
    int        seg_idx;
    int        rnd_sent;
    int        ins_pct;
    int        spread;
    seg_kind_t kind;
    cmd_t      c;

    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;

    // directed items: empty heap, edge keys, equal keys, child ties,
    // a lone left child and a climb all the way to the root
    dir_table = '{
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b1, EMPTY_TOP},
      {ACT_INSERT, 16'h0000, 16'h0000, 1'b1, {16'h0000, 16'h0000, 7'd1, 1'b0, 1'b0}},
      {ACT_INSERT, 16'hffff, 16'hffff, 1'b1, {16'hffff, 16'hffff, 7'd2, 1'b0, 1'b0}},
      {ACT_INSERT, 16'hffff, 16'h1234, 1'b0, NO_WANT},
      {ACT_INSERT, 16'h8000, 16'haaaa, 1'b0, NO_WANT},
      {ACT_INSERT, 16'h7fff, 16'h5555, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'hffff, 16'hffff, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h5a5a, 16'ha5a5, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b1, EMPTY_TOP},
      {ACT_REMOVE, 16'hffff, 16'hffff, 1'b1, EMPTY_TOP},
      {ACT_INSERT, 16'h000a, 16'h0001, 1'b0, NO_WANT},
      {ACT_INSERT, 16'h0005, 16'h0002, 1'b0, NO_WANT},
      {ACT_INSERT, 16'h0005, 16'h0003, 1'b0, NO_WANT},
      {ACT_INSERT, 16'h0001, 16'h0004, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_INSERT, 16'hffff, 16'h0007, 1'b0, NO_WANT},
      {ACT_INSERT, 16'h0000, 16'hffff, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
      {ACT_REMOVE, 16'hffff, 16'h0000, 1'b1, EMPTY_TOP}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 24; i++) begin
      offer_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].want);
      maybe_idle();
    end

    // random part in segments: fill to overflow, drain past empty,
    // even mixes, and mixes over a handful of keys to force ties
    rnd_sent = 0;
    seg_idx = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      kind = (seg_idx == 0) ? SEG_FILL : seg_kind_t'($urandom_range(0, 3));
      case (kind)
        SEG_FILL: begin
          ins_pct = 93;
          seg_len = $urandom_range(80, 100);
        end
        SEG_DRAIN: begin
          ins_pct = 10;
          seg_len = $urandom_range(70, 90);
        end
        SEG_MIXED: begin
          ins_pct = 50;
          seg_len = $urandom_range(20, 60);
        end
        default: begin
          ins_pct = 55;
          seg_len = $urandom_range(20, 60);
        end
      endcase
      for (j = 0; j < seg_len && rnd_sent < RANDOM_ITEMS; j++) begin
        c.action = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
        if (kind == SEG_TIES) begin
          c.entry_key = KEY_W'($urandom_range(0, 3));
        end else begin
          spread = $urandom_range(0, 99);
          c.entry_key = pick_key(spread < 70 ? 0 : (spread < 85 ? 1 : 2));
        end
        c.entry_tag = TAG_W'($urandom());
        offer_cmd(c, 1'b0, NO_WANT);
        rnd_sent++;
        if (rnd_sent >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
        if (rnd_sent == PAUSE_AT) begin
          // sender goes quiet until the block has answered everything
          cmd_valid <= 1'b0;
          while (pending_tops.size() != 0) @(posedge clk);
        end else begin
          maybe_idle();
        end
      end
      seg_idx++;
    end

    cmd_valid <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("ran %0d items: %0d inserts (%0d dropped when full), %0d removes (%0d on empty)",
             n_insert + n_remove, n_insert, n_dropped, n_remove, n_empty_remove);
    $display("heap peaked at %0d of %0d entries; %0d results checked, %0d mismatches",
             peak_fill, HQ_CAPACITY, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
